// ----- hdl/overstrike_to_printer_escape_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Overstrike to printer escape unit: assertion macros
// Shorthand for the concurrent checks, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef OVERSTRIKE_TO_PRINTER_ESCAPE_UNIT_MACROS_SVH
`define OVERSTRIKE_TO_PRINTER_ESCAPE_UNIT_MACROS_SVH

// Check an implication within the same cycle
`define OTPE_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check an implication in the next cycle
`define OTPE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/otpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Overstrike to printer escape package
// Word types, character codes, register indexes and the job descriptor.
// ----------------------------------------------------------------------------
package otpe_pkg;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SO    = 8'h0E;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BOLD_ON  = 8'h45;
    localparam logic [7:0] CH_BOLD_OFF = 8'h46;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] ITALIC_BIT = 8'h80;

    // Indent limits and widths
    localparam int MAX_INDENT = 24;
    localparam int LEAD_W     = 5;   // wide-on byte plus up to MAX_INDENT spaces
    localparam int PRE_MAX    = 5;   // longest plain byte run (bold sequence)
    localparam int PRE_CNT_W  = 3;
    localparam int POS_W      = 6;   // two leads, five bytes, three newlines

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_INDENT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SPACING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROMAN_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_STRIKE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS_FF    = 3'd5;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Input word
    typedef struct packed {
        logic       command;     // 0 text byte, 1 end of file
        logic [7:0] text_byte;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_word_t;

    // Output job for one accepted input: lead, plain bytes, newlines, lead
    typedef struct packed {
        logic                          wide;
        logic [LEAD_W-1:0]             lead_pre_len;
        logic [PRE_CNT_W-1:0]          pre_cnt;
        logic [PRE_MAX-1:0][7:0]       pre_bytes;
        logic [1:0]                    nl_cnt;
        logic [LEAD_W-1:0]             lead_post_len;
    } job_t;

endpackage

// ----- hdl/otpe_front.sv -----
// ----------------------------------------------------------------------------
// Overstrike to printer escape front end
// Holds the configuration, tracks overstrike state and turns each input word
// into an output job for the back end.
// ----------------------------------------------------------------------------
module otpe_front
    import otpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  in_word_t              in_word,
    output logic                  job_push,
    output job_t                  job
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HELD = 4'b0010,
        PH_ITAL = 4'b0100,
        PH_BOLD = 4'b1000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        held_reg, held_next;
    logic              indent_due_reg, indent_due_next;

    logic [4:0]        indent_count_reg;
    logic [1:0]        line_spacing_reg;
    logic              roman_mode_reg;
    logic              double_strike_reg;
    logic              wide_mode_reg;
    logic              suppress_ff_reg;

    logic [LEAD_W-1:0] indent_sat;
    logic [LEAD_W-1:0] lead_len;
    logic [7:0]        c;
    logic              do_fresh;
    logic [PRE_CNT_W-1:0] cnt;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            indent_count_reg  <= '0;
            line_spacing_reg  <= 2'd1;
            roman_mode_reg    <= 1'b0;
            double_strike_reg <= 1'b0;
            wide_mode_reg     <= 1'b0;
            suppress_ff_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INDENT_COUNT:  indent_count_reg  <= cfg_data[4:0];
                REG_LINE_SPACING:  line_spacing_reg  <= cfg_data[1:0];
                REG_ROMAN_MODE:    roman_mode_reg    <= cfg_data[0];
                REG_DOUBLE_STRIKE: double_strike_reg <= cfg_data[0];
                REG_WIDE_MODE:     wide_mode_reg     <= cfg_data[0];
                REG_SUPPRESS_FF:   suppress_ff_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Saturate the indent and add the wide-on byte
    assign indent_sat = (indent_count_reg > LEAD_W'(MAX_INDENT)) ?
                        LEAD_W'(MAX_INDENT) : indent_count_reg;
    assign lead_len   = indent_sat + LEAD_W'(wide_mode_reg);
    assign c          = in_word.text_byte;

    // Classify the word and build its job
    always_comb
    begin
        job             = '0;
        job.wide        = wide_mode_reg;
        job.lead_pre_len = indent_due_reg ? lead_len : '0;
        cnt             = '0;
        do_fresh        = 1'b0;
        phase_next      = phase_reg;
        held_next       = held_reg;
        indent_due_next = 1'b0;

        if (in_word.command)
        begin
            // End of file: flush what is held, then the form feed unless suppressed
            unique case (phase_reg) inside
                PH_HELD:
                begin
                    job.pre_bytes[0] = held_reg;
                    cnt = 3'd1;
                end
                PH_ITAL, PH_BOLD:
                begin
                    job.pre_bytes[0] = held_reg;
                    job.pre_bytes[1] = CH_BS;
                    cnt = 3'd2;
                end
                default: ;
            endcase
            if (!suppress_ff_reg)
            begin
                job.pre_bytes[cnt] = CH_FF;
                cnt = cnt + 3'd1;
            end
            phase_next      = PH_IDLE;
            indent_due_next = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                    do_fresh = 1'b1;
                PH_HELD:
                begin
                    if (c != CH_BS)
                    begin
                        job.pre_bytes[0] = held_reg;
                        cnt = 3'd1;
                        phase_next = PH_IDLE;
                        do_fresh = 1'b1;
                    end
                    else if (held_reg == CH_UNDER && !roman_mode_reg)
                        phase_next = PH_ITAL;
                    else if (!double_strike_reg)
                        phase_next = PH_BOLD;
                    else
                    begin
                        // Plain overstrike: send the byte, hold the backspace
                        job.pre_bytes[0] = held_reg;
                        cnt = 3'd1;
                        held_next = CH_BS;
                    end
                end
                PH_ITAL:
                begin
                    job.pre_bytes[0] = c + ITALIC_BIT;
                    cnt = 3'd1;
                    phase_next = PH_IDLE;
                end
                PH_BOLD:
                begin
                    if (c == held_reg)
                    begin
                        job.pre_bytes[0] = CH_ESC;
                        job.pre_bytes[1] = CH_BOLD_ON;
                        job.pre_bytes[2] = held_reg;
                        job.pre_bytes[3] = CH_ESC;
                        job.pre_bytes[4] = CH_BOLD_OFF;
                        cnt = 3'd5;
                    end
                    else
                    begin
                        job.pre_bytes[0] = held_reg;
                        job.pre_bytes[1] = CH_BS;
                        cnt = 3'd2;
                        do_fresh = 1'b1;
                    end
                    phase_next = PH_IDLE;
                end
                default: ;
            endcase

            // Handle a fresh byte: newline, form feed or hold it
            if (do_fresh)
            begin
                if (c == CH_NL)
                begin
                    job.nl_cnt        = line_spacing_reg;
                    job.lead_post_len = lead_len;
                end
                else if (c == CH_FF)
                begin
                    job.pre_bytes[cnt] = CH_FF;
                    cnt = cnt + 3'd1;
                    job.lead_post_len = lead_len;
                end
                else
                begin
                    held_next  = c;
                    phase_next = PH_HELD;
                end
            end
        end
        job.pre_cnt = cnt;
    end

    // Drop jobs that send nothing
    assign job_push = accept && (|{job.lead_pre_len, job.pre_cnt, job.nl_cnt,
                                   job.lead_post_len});

    // Advance the overstrike state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_reg       <= '0;
            indent_due_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            indent_due_reg <= indent_due_next;
        end
    end

endmodule

// ----- hdl/otpe_queue.sv -----
// ----------------------------------------------------------------------------
// Overstrike to printer escape job queue
// Short first-in first-out store of jobs between front and back end.
// ----------------------------------------------------------------------------
module otpe_queue
    import otpe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    input  logic rd_en,
    output job_t rd_data,
    output logic full,
    output logic valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = store[rd_ptr_reg];

    // Store the incoming job
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hdl/otpe_back.sv -----
// ----------------------------------------------------------------------------
// Overstrike to printer escape back end
// Walks the head job one byte a cycle into the result register, while that register is empty or being popped.
// ----------------------------------------------------------------------------
module otpe_back
    import otpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_done,
    input  logic      pop,
    output logic      empty,
    output out_word_t out_word
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] end_a, end_b, end_c, end_d;
    logic [POS_W-1:0] lead_pos;
    logic [POS_W-1:0] pre_pos;
    logic             in_lead;
    logic [7:0]       byte_sel;
    logic             is_last;
    logic             step;
    logic             out_valid_reg;
    out_word_t        out_word_reg;

    // Segment boundaries of the head job
    assign end_a = POS_W'(job.lead_pre_len);
    assign end_b = end_a + POS_W'(job.pre_cnt);
    assign end_c = end_b + POS_W'(job.nl_cnt);
    assign end_d = end_c + POS_W'(job.lead_post_len);
    assign pre_pos = pos_reg - end_a;

    // Select the byte at the current position
    always_comb
    begin
        in_lead  = 1'b0;
        lead_pos = '0;
        byte_sel = CH_NL;
        if (pos_reg < end_a)
        begin
            in_lead  = 1'b1;
            lead_pos = pos_reg;
        end
        else if (pos_reg < end_b)
            byte_sel = job.pre_bytes[pre_pos[PRE_CNT_W-1:0]];
        else if (pos_reg >= end_c)
        begin
            in_lead  = 1'b1;
            lead_pos = pos_reg - end_c;
        end
        if (in_lead)
            byte_sel = (job.wide && lead_pos == '0) ? CH_SO : CH_SP;
    end

    assign is_last  = (pos_reg == end_d - 1'b1);
    assign step     = job_valid && (!out_valid_reg || pop);
    assign job_done = step && is_last;

    // Advance through the job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
                pos_reg <= is_last ? '0 : pos_reg + 1'b1;
            if (step)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_word_reg.out_byte <= byte_sel;
            out_word_reg.last     <= is_last;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_word = out_word_reg;

endmodule

// ----- hdl/overstrike_to_printer_escape_unit.sv -----
// ----------------------------------------------------------------------------
// Overstrike to printer escape unit
// Converts text bytes with backspace overstrikes into printer bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue: present in_word and raise push; the word is taken on a
//   clock edge with full low. command 1 marks end of file.
//   Results are a queue too: while empty is low, out_word holds the oldest
//   byte; pop takes it. last marks the final byte caused by one input word.
//   Configuration writes (cfg_index, cfg_data) are always ready and belong in
//   idle periods; indexes above five are ignored.
//   Throughput: one input word a cycle while each word makes at most one byte
//   and pop keeps up; a word with more bytes (indents, newlines, bold sequences)
//   holds the byte generator until its last byte is out, and the job queue of
//   QUEUE_DEPTH entries lets input run ahead meanwhile. Full rises once it fills.
//   With the queue and result register idle, a word's job enters the job queue
//   on the edge that takes it, and its first byte then loads into out_word.
//   A word that causes no byte leaves no trace on the result side.
//   Stalling pop holds the result word and backs up into the queue and full.
//   Reset clears the queue and state; the first word of a file is preceded by
//   the indent.
// ----------------------------------------------------------------------------
module overstrike_to_printer_escape_unit
    import otpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  in_word_t              in_word,
    output logic                  empty,
    input  logic                  pop,
    output out_word_t             out_word
);

    logic accept;
    logic job_push;
    job_t job_in;
    job_t job_head;
    logic job_valid;
    logic job_done;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // Classify input words
    otpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_word   (in_word),
        .job_push  (job_push),
        .job       (job_in)
    );

    // Buffer jobs
    otpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_done),
        .rd_data (job_head),
        .full    (full),
        .valid   (job_valid)
    );

    // Emit printer bytes
    otpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_done  (job_done),
        .pop       (pop),
        .empty     (empty),
        .out_word  (out_word)
    );

endmodule

// ----- hdl/otpe_checker.sv -----
// ----------------------------------------------------------------------------
// Overstrike to printer escape checker
// Port-level checks on the queue handshakes and configuration channel.
// ----------------------------------------------------------------------------
`include "overstrike_to_printer_escape_unit_macros.svh"

module otpe_checker
    import otpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic                  push,
    input  logic                  full,
    input  logic                  empty,
    input  logic                  pop,
    input  out_word_t             out_word
);

    // A waiting word that is not taken stays and holds its value
    `OTPE_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(out_word), "result word changed while stalled")

    // The queue only fills through an accepted input word
    `OTPE_ASSERT_NEXT(a_full_needs_push, !full && !(push && !full), !full, "full rose without an accepted word")

    // Configuration writes are never refused
    `OTPE_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind overstrike_to_printer_escape_unit otpe_checker u_otpe_checker (.*);

// ----- bench/overstrike_to_printer_escape_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overstrike to printer escape unit: testbench
// Feeds text words and end-of-file words through the input queue under a
// range of register settings. A scoreboard predicts every printer byte and
// checks what comes out of the result queue, in order. Both queue sides idle
// at random. The run opens with a short directed sequence, then random ones.
// ----------------------------------------------------------------------------
module overstrike_to_printer_escape_unit_tb;
    import otpe_pkg::*;

    localparam int   CYCLE_LIMIT = 600000;
    localparam int   SETTLE_CYCLES = 16;
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    // What the converter is holding back between words
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_BYTE,
        HOLD_ITALIC,
        HOLD_BOLD
    } hold_t;

    // Predict printer bytes and check them in arrival order
    class printer_byte_scoreboard;
        logic [4:0] indent_count;
        logic [1:0] line_spacing;
        logic       roman_mode;
        logic       double_strike;
        logic       wide_mode;
        logic       suppress_ff;
        hold_t      hold;
        logic [7:0] held_byte;
        logic       indent_due;
        logic [7:0] burst[$];
        out_word_t  printer_bytes_due[$];
        int         checked;
        int         mismatches;

        function new();
            indent_count  = '0;
            line_spacing  = 2'd1;
            roman_mode    = 1'b0;
            double_strike = 1'b0;
            wide_mode     = 1'b0;
            suppress_ff   = 1'b0;
            hold          = HOLD_NONE;
            held_byte     = '0;
            indent_due    = 1'b1;
            checked       = 0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INDENT_COUNT:  indent_count  = data[4:0];
                REG_LINE_SPACING:  line_spacing  = data[1:0];
                REG_ROMAN_MODE:    roman_mode    = data[0];
                REG_DOUBLE_STRIKE: double_strike = data[0];
                REG_WIDE_MODE:     wide_mode     = data[0];
                REG_SUPPRESS_FF:   suppress_ff   = data[0];
                default: ;
            endcase
        endfunction

        // Indent: optional wide-on byte, then spaces saturated at the maximum
        function void add_lead();
            int n;
            n = (indent_count > MAX_INDENT) ? MAX_INDENT : indent_count;
            if (wide_mode)
                burst.push_back(CH_SO);
            repeat (n) burst.push_back(CH_SP);
        endfunction

        // Handle a byte with nothing held in front of it
        function void take_fresh(logic [7:0] c);
            if (c == CH_NL) begin
                repeat (line_spacing) burst.push_back(CH_NL);
                add_lead();
            end else if (c == CH_FF) begin
                burst.push_back(CH_FF);
                add_lead();
            end else begin
                held_byte = c;
                hold = HOLD_BYTE;
            end
        endfunction

        function void note_input(in_word_t w);
            out_word_t r;
            burst.delete();
            if (indent_due) begin
                add_lead();
                indent_due = 1'b0;
            end
            if (w.command == CMD_EOF) begin
                // flush whatever is held, a pending backspace mark included
                if (hold != HOLD_NONE)
                    burst.push_back(held_byte);
                if (hold == HOLD_ITALIC || hold == HOLD_BOLD)
                    burst.push_back(CH_BS);
                hold = HOLD_NONE;
                if (!suppress_ff)
                    burst.push_back(CH_FF);
                indent_due = 1'b1;
            end else begin
                case (hold)
                    HOLD_NONE: take_fresh(w.text_byte);
                    HOLD_BYTE:
                        if (w.text_byte != CH_BS) begin
                            burst.push_back(held_byte);
                            hold = HOLD_NONE;
                            take_fresh(w.text_byte);
                        end else if (held_byte == CH_UNDER && !roman_mode) begin
                            hold = HOLD_ITALIC;
                        end else if (!double_strike) begin
                            hold = HOLD_BOLD;
                        end else begin
                            burst.push_back(held_byte);
                            held_byte = CH_BS;
                        end
                    HOLD_ITALIC: begin
                        burst.push_back(8'(w.text_byte + ITALIC_BIT));
                        hold = HOLD_NONE;
                    end
                    default:
                        if (w.text_byte == held_byte) begin
                            burst.push_back(CH_ESC);
                            burst.push_back(CH_BOLD_ON);
                            burst.push_back(held_byte);
                            burst.push_back(CH_ESC);
                            burst.push_back(CH_BOLD_OFF);
                            hold = HOLD_NONE;
                        end else begin
                            burst.push_back(held_byte);
                            burst.push_back(CH_BS);
                            hold = HOLD_NONE;
                            take_fresh(w.text_byte);
                        end
                endcase
            end
            foreach (burst[i]) begin
                r.out_byte = burst[i];
                r.last = (i == burst.size() - 1);
                printer_bytes_due.push_back(r);
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_byte(out_word_t got);
            out_word_t exp;
            if (printer_bytes_due.size() == 0) begin
                flag($sformatf("byte %02h last %0b with nothing expected",
                               got.out_byte, got.last));
                return;
            end
            exp = printer_bytes_due.pop_front();
            checked++;
            if (got.out_byte !== exp.out_byte || got.last !== exp.last)
                flag($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                               exp.out_byte, exp.last, got.out_byte, got.last));
        endfunction

        function int pending();
            return printer_bytes_due.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    in_word_t              in_word = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    out_word_t             out_word;

    printer_byte_scoreboard sb;
    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int items_taken = 0;
    int settings_done = 0;
    int cycle_count = 0;

    overstrike_to_printer_escape_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

    always #5 clk = ~clk;

    // Drop pop at random to stall the result side
    always @(posedge clk)
        pop <= ($urandom_range(0, 99) >= take_idle_pct);

    // Watch every handshake; check results before noting new input
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (pop && !empty)
                sb.check_byte(out_word);
            if (push && !full) begin
                sb.note_input(in_word);
                items_taken++;
            end
        end
    end

    // Hold push with a random gap in front; return once the word is taken
    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_text(input logic [7:0] c);
        in_word_t w;
        w.command = CMD_TEXT;
        w.text_byte = c;
        send_word(w);
    endtask

    task automatic send_eof();
        in_word_t w;
        w.command = CMD_EOF;
        w.text_byte = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Write every register, plus one index that the block ignores
    task automatic configure_unit(input logic [4:0] indent, input logic [4:0] spacing,
                                  input logic [4:0] roman, input logic [4:0] dstrike,
                                  input logic [4:0] wide, input logic [4:0] no_ff);
        write_reg(REG_INDENT_COUNT, indent);
        write_reg(REG_LINE_SPACING, spacing);
        write_reg(REG_ROMAN_MODE, roman);
        write_reg(REG_DOUBLE_STRIKE, dstrike);
        write_reg(REG_WIDE_MODE, wide);
        write_reg(REG_SUPPRESS_FF, no_ff);
        write_reg(CFG_IDX_W'($urandom_range(6, 7)), CFG_DATA_W'($urandom_range(0, 31)));
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_done++;
    endtask

    // Stop pushing, let the last word be noted, wait for every expected byte,
    // then let the pipe settle
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Bias towards the bytes that steer the converter
    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 9))
            0:       return CH_BS;
            1:       return CH_NL;
            2:       return CH_FF;
            3:       return CH_UNDER;
            4, 5:    return 8'h61 + 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed overstrike runs, with noise mixed in
    task automatic run_random(input int n);
        int sent;
        int kind;
        logic [7:0] c;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 99);
            c = pick_text();
            if (kind < 20) begin
                send_text(c);
                sent += 1;
            end else if (kind < 35) begin
                send_text(CH_UNDER);
                send_text(CH_BS);
                send_text(c);
                sent += 3;
            end else if (kind < 52) begin
                send_text(c);
                send_text(CH_BS);
                send_text(c);
                sent += 3;
            end else if (kind < 62) begin
                send_text(c);
                send_text(CH_BS);
                send_text(pick_text());
                sent += 3;
            end else if (kind < 70) begin
                send_text(CH_NL);
                sent += 1;
            end else if (kind < 75) begin
                send_text(CH_FF);
                sent += 1;
            end else if (kind < 81) begin
                send_eof();
                sent += 1;
            end else if (kind < 88) begin
                send_text(CH_BS);
                sent += 1;
            end else if (kind < 93) begin
                // overstrike cut off by end of file
                send_text(c);
                send_text(CH_BS);
                send_eof();
                sent += 3;
            end else begin
                send_text(8'($urandom_range(0, 255)));
                sent += 1;
            end
        end
    endtask

    // Give up on a hang
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("overstrike_to_printer_escape_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: visible indent, double newlines
        send_idle_pct = 21;
        take_idle_pct = 72;
        configure_unit(5'd2, 5'd2, 5'd0, 5'd0, 5'd1, 5'd0);
        send_eof();                  // end of file as the very first word
        send_text("A");
        send_text(CH_UNDER);
        send_text(CH_BS);
        send_text("x");              // italic
        send_text(CH_UNDER);
        send_text(CH_BS);
        send_text(8'hFF);            // italic wraps to 8 bits
        send_text(CH_UNDER);
        send_text(CH_BS);
        send_text(CH_NL);            // newline as italic target gets the italic bit
        send_text("b");
        send_text(CH_BS);
        send_text("b");              // bold
        send_text("c");
        send_text(CH_BS);
        send_text("d");              // failed bold compare
        send_text(CH_NL);
        send_text(CH_FF);
        send_text(CH_UNDER);
        send_text(CH_BS);
        send_eof();                  // underscore-backspace cut off
        send_text(8'h00);
        send_eof();
        wait_idle();

        // Random part over a spread of settings
        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                send_idle_pct = 72;
                take_idle_pct = 21;
            end else if (p == 6) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            case (p)
                0: configure_unit(5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0);
                1: configure_unit(5'd24, 5'd3, 5'd1, 5'd0, 5'd1, 5'd0);
                2: configure_unit(5'd31, 5'd0, 5'd0, 5'd1, 5'd0, 5'd1);
                4: configure_unit(5'd5, 5'd2, 5'd1, 5'd1, 5'd1, 5'd1);
                7: configure_unit(5'd1, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0);
                default:
                    configure_unit(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            endcase
            run_random(50);
            wait_idle();
        end

        if (sb.pending() != 0)
            sb.flag($sformatf("%0d bytes never arrived", sb.pending()));
        $display("run covered %0d input words and %0d printer bytes over %0d settings",
                 items_taken, sb.checked, settings_done);
        $display("mismatches counted: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("overstrike_to_printer_escape_unit regression: pass");
        else
            $display("overstrike_to_printer_escape_unit regression: fail");
        $finish;
    end

endmodule
